// File: sv/mld_pkg.sv
// ----------------------------------------------------------------------------
// mld_pkg: shared types and constants for the mipmap line downsampler
// Holds the sizing constants, payload structs, lane control struct and the
// filter mode and register index codes.
// ----------------------------------------------------------------------------
package mld_pkg;

    localparam int MAX_LINE     = 4096;
    localparam int CHANNEL_BITS = 16;
    localparam int WEIGHT_BITS  = 16;

    // position in a line and effective line length
    localparam int POS_W  = $clog2(MAX_LINE);
    localparam int LEN_W  = POS_W + 1;
    // three-tap weighted sum before scaling, and after scaling by the reciprocal
    localparam int SUM_W  = CHANNEL_BITS + POS_W + 2;
    localparam int PROD_W = SUM_W + WEIGHT_BITS;

    // register field widths
    localparam int LINE_LEN_BITS = 13;
    localparam int RECIP_BITS    = 16;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_LINE_LENGTH  = 1'b0;
    localparam logic REG_RECIP_LENGTH = 1'b1;

    localparam logic [LINE_LEN_BITS-1:0] LINE_LENGTH_RESET = LINE_LEN_BITS'(2);
    localparam logic [RECIP_BITS-1:0]    RECIP_LENGTH_RESET = '0;

    // lane filter modes
    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_AVG  = 2'd1;
    localparam logic [1:0] MODE_TRI  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] chan_x;
        logic [CHANNEL_BITS-1:0] chan_y;
        logic [CHANNEL_BITS-1:0] chan_z;
    } pix_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] out_x;
        logic [CHANNEL_BITS-1:0] out_y;
        logic [CHANNEL_BITS-1:0] out_z;
        logic [POS_W-1:0]        out_index;
        logic                    line_done;
    } res_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic             emit;
        logic             store_first;
        logic             store_middle;
        logic [POS_W-1:0] c0;
        logic [POS_W-1:0] c1;
        logic [POS_W-1:0] c2;
        logic [POS_W-1:0] index;
        logic             last;
    } lane_ctl_t;

endpackage

// File: sv/mld_ctrl.sv
// ----------------------------------------------------------------------------
// mld_ctrl: line position sequencer
// Tracks the parent and reduced positions in the line and derives the
// filter mode, tap weights and hold strobes shared by all lanes.
// ----------------------------------------------------------------------------
module mld_ctrl
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [mld_pkg::LINE_LEN_BITS-1:0] line_length,
    input  logic                              restart,
    input  logic                              accept,
    output mld_pkg::lane_ctl_t                ctl
);

    logic [mld_pkg::POS_W-1:0] in_pos_reg;
    logic [mld_pkg::POS_W-1:0] in_pos_next;
    logic [mld_pkg::POS_W-1:0] out_pos_reg;
    logic [mld_pkg::POS_W-1:0] out_pos_next;

    logic [mld_pkg::LEN_W-1:0] len;
    logic [mld_pkg::LEN_W-1:0] len_m1;
    logic [mld_pkg::POS_W-1:0] n;
    logic [mld_pkg::POS_W-1:0] k;
    logic                      last;

    // clamp the programmed length to 1..MAX_LINE
    always_comb
    begin
        if (line_length == '0)
        begin
            len = mld_pkg::LEN_W'(1);
        end
        else if (int'(line_length) > mld_pkg::MAX_LINE)
        begin
            len = mld_pkg::LEN_W'(mld_pkg::MAX_LINE);
        end
        else
        begin
            len = mld_pkg::LEN_W'(line_length);
        end
    end

    assign len_m1 = len - mld_pkg::LEN_W'(1);
    assign last   = {1'b0, in_pos_reg} >= len_m1;
    assign n      = len[mld_pkg::LEN_W-1:1];

    always_comb
    begin
        k = mld_pkg::POS_W'(in_pos_reg[mld_pkg::POS_W-1:1]) - mld_pkg::POS_W'(1);
        if (k >= n)
        begin
            k = n - mld_pkg::POS_W'(1);
        end
    end

    always_comb
    begin
        ctl              = '0;
        ctl.c0           = n - k;
        ctl.c1           = n;
        ctl.c2           = k + mld_pkg::POS_W'(1);
        ctl.index        = out_pos_reg;
        ctl.last         = last;
        ctl.mode         = mld_pkg::MODE_NONE;
        if (len == mld_pkg::LEN_W'(1))
        begin
            ctl.mode = mld_pkg::MODE_PASS;
            ctl.emit = 1'b1;
        end
        else if (!len[0])
        begin
            if (!in_pos_reg[0])
            begin
                ctl.store_first = 1'b1;
            end
            else
            begin
                ctl.mode = mld_pkg::MODE_AVG;
                ctl.emit = 1'b1;
            end
        end
        else if (in_pos_reg[0])
        begin
            ctl.store_middle = 1'b1;
        end
        else if (in_pos_reg == '0)
        begin
            ctl.store_first = 1'b1;
        end
        else
        begin
            ctl.mode        = mld_pkg::MODE_TRI;
            ctl.emit        = 1'b1;
            ctl.store_first = 1'b1;
        end
    end

    always_comb
    begin
        in_pos_next  = in_pos_reg;
        out_pos_next = out_pos_reg;
        if (restart)
        begin
            in_pos_next  = '0;
            out_pos_next = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                in_pos_next  = '0;
                out_pos_next = '0;
            end
            else
            begin
                in_pos_next  = in_pos_reg + mld_pkg::POS_W'(1);
                out_pos_next = out_pos_reg + mld_pkg::POS_W'(ctl.emit);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pos_reg  <= '0;
            out_pos_reg <= '0;
        end
        else
        begin
            in_pos_reg  <= in_pos_next;
            out_pos_reg <= out_pos_next;
        end
    end

endmodule

// File: sv/mld_lane.sv
// ----------------------------------------------------------------------------
// mld_lane: one channel of the line filter
// Holds the first and middle pixels of the current pair or triple, forms the
// pass, average or weighted sum, and scales, rounds and saturates the weighted sum.
// ----------------------------------------------------------------------------
module mld_lane
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  mld_pkg::lane_ctl_t               ctl,
    input  logic [mld_pkg::CHANNEL_BITS-1:0] pix_chan,
    input  logic [mld_pkg::RECIP_BITS-1:0]   recip,
    output logic [mld_pkg::CHANNEL_BITS-1:0] res_chan
);

    localparam int CB = mld_pkg::CHANNEL_BITS;
    localparam int WB = mld_pkg::WEIGHT_BITS;
    localparam logic [mld_pkg::PROD_W-1:0] HALF = mld_pkg::PROD_W'(1) << (WB - 1);
    localparam logic [mld_pkg::SUM_W-1:0]  FULL = mld_pkg::SUM_W'({CB{1'b1}});

    logic [CB-1:0]              first_reg;
    logic [CB-1:0]              middle_reg;
    logic [mld_pkg::SUM_W-1:0]  s1_val_reg;
    logic [mld_pkg::SUM_W-1:0]  s1_val_next;
    logic                       s1_tri_reg;

    logic [CB:0]                avg_sum;
    logic [mld_pkg::PROD_W-1:0] scaled;
    logic [mld_pkg::SUM_W-1:0]  quot;

    assign avg_sum = {1'b0, first_reg} + {1'b0, pix_chan} + (CB+1)'(1);

    always_comb
    begin
        case (ctl.mode)
            mld_pkg::MODE_AVG:
                s1_val_next = mld_pkg::SUM_W'(avg_sum[CB:1]);
            mld_pkg::MODE_TRI:
                s1_val_next = mld_pkg::SUM_W'(ctl.c0) * mld_pkg::SUM_W'(first_reg)
                            + mld_pkg::SUM_W'(ctl.c1) * mld_pkg::SUM_W'(middle_reg)
                            + mld_pkg::SUM_W'(ctl.c2) * mld_pkg::SUM_W'(pix_chan);
            default:
                s1_val_next = mld_pkg::SUM_W'(pix_chan);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            middle_reg <= '0;
        end
        else if (accept)
        begin
            if (ctl.store_first)
            begin
                first_reg <= pix_chan;
            end
            if (ctl.store_middle)
            begin
                middle_reg <= pix_chan;
            end
        end
    end

    // stage-1 value; advances only with an item that produces a result
    always_ff @(posedge clk)
    begin
        if (accept && ctl.emit)
        begin
            s1_val_reg <= s1_val_next;
            s1_tri_reg <= (ctl.mode == mld_pkg::MODE_TRI);
        end
    end

    // scale by the reciprocal, round half up, saturate at full scale
    assign scaled = mld_pkg::PROD_W'(s1_val_reg) * mld_pkg::PROD_W'(WB'(recip)) + HALF;
    assign quot   = scaled[mld_pkg::PROD_W-1:WB];

    always_comb
    begin
        if (!s1_tri_reg)
        begin
            res_chan = s1_val_reg[CB-1:0];
        end
        else if (quot > FULL)
        begin
            res_chan = {CB{1'b1}};
        end
        else
        begin
            res_chan = quot[CB-1:0];
        end
    end

endmodule

// File: sv/mipmap_line_downsampler.sv
// ----------------------------------------------------------------------------
// mipmap_line_downsampler: halves one parent pixel line for a mipmap level
// Three channel lanes share one position sequencer; the output register
// merges the lane results with the reduced index and end-of-line flag.
// ----------------------------------------------------------------------------
// Path: a result item enters the stage-1 sum register at the edge that accepts
//   its last parent pixel, then moves into the output register when that is free.
// Throughput: one pixel item per cycle; stage 1 and the output register
//   each hold one result, so input stalls only while both hold one and res stalls.
// Reset: rst_n clears line positions, held pixels and valid flags at once;
//   line_length resets to 2 and recip_length to 0. No clearing pass.
// ----------------------------------------------------------------------------
module mipmap_line_downsampler
(
    input  logic                       clk,
    input  logic                       rst_n,
    // parent pixel channel
    input  logic                       pix_valid,
    output logic                       pix_stall,
    input  mld_pkg::pix_t              pix,
    // reduced pixel channel
    output logic                       res_valid,
    input  logic                       res_stall,
    output mld_pkg::res_t              res,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mld_pkg::ADDR_W-1:0] paddr,
    input  logic [mld_pkg::DATA_W-1:0] pwdata,
    output logic [mld_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [mld_pkg::LINE_LEN_BITS-1:0] line_length_reg;
    logic [mld_pkg::RECIP_BITS-1:0]    recip_length_reg;

    logic                      cfg_write;
    logic                      restart;
    logic                      accept;
    logic                      out_free;
    logic                      s1_move;
    mld_pkg::lane_ctl_t        ctl;

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic [mld_pkg::POS_W-1:0] s1_index_reg;
    logic                      s1_last_reg;
    logic                      res_valid_reg;
    logic                      res_valid_next;
    mld_pkg::res_t             res_reg;

    logic [mld_pkg::CHANNEL_BITS-1:0] lane_x;
    logic [mld_pkg::CHANNEL_BITS-1:0] lane_y;
    logic [mld_pkg::CHANNEL_BITS-1:0] lane_z;

    // ------------------------------------------------------------------
    // Configuration registers: a write completes in the access phase.
    // Rewriting line_length abandons the line in progress.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign restart   = cfg_write && (paddr[2] == mld_pkg::REG_LINE_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg  <= mld_pkg::LINE_LENGTH_RESET;
            recip_length_reg <= mld_pkg::RECIP_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                mld_pkg::REG_LINE_LENGTH:
                    line_length_reg <= pwdata[mld_pkg::LINE_LEN_BITS-1:0];
                mld_pkg::REG_RECIP_LENGTH:
                    recip_length_reg <= pwdata[mld_pkg::RECIP_BITS-1:0];
                default:
                    line_length_reg <= line_length_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            mld_pkg::REG_LINE_LENGTH:
                prdata = mld_pkg::DATA_W'(line_length_reg);
            mld_pkg::REG_RECIP_LENGTH:
                prdata = mld_pkg::DATA_W'(recip_length_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: the output register takes a new item when empty or
    // when its item leaves; stage 1 advances into it whenever it can.
    // Accept a pixel unless stage 1 is full and cannot advance.
    // ------------------------------------------------------------------
    assign out_free  = !res_valid_reg || !res_stall;
    assign s1_move   = s1_valid_reg && out_free;
    assign pix_stall = s1_valid_reg && !out_free;
    assign accept    = pix_valid && !pix_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept && ctl.emit)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (s1_move)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and lanes
    // ------------------------------------------------------------------
    mld_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_length (line_length_reg),
        .restart     (restart),
        .accept      (accept),
        .ctl         (ctl)
    );

    mld_lane u_lane_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .ctl      (ctl),
        .pix_chan (pix.chan_x),
        .recip    (recip_length_reg),
        .res_chan (lane_x)
    );

    mld_lane u_lane_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .ctl      (ctl),
        .pix_chan (pix.chan_y),
        .recip    (recip_length_reg),
        .res_chan (lane_y)
    );

    mld_lane u_lane_z
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .ctl      (ctl),
        .pix_chan (pix.chan_z),
        .recip    (recip_length_reg),
        .res_chan (lane_z)
    );

    // hold the index and end-of-line flag alongside the lane sums
    always_ff @(posedge clk)
    begin
        if (accept && ctl.emit)
        begin
            s1_index_reg <= ctl.index;
            s1_last_reg  <= ctl.last;
        end
    end

    // ------------------------------------------------------------------
    // Merge stage: combine the three lane results into the result item
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            res_reg.out_x     <= lane_x;
            res_reg.out_y     <= lane_y;
            res_reg.out_z     <= lane_z;
            res_reg.out_index <= s1_index_reg;
            res_reg.line_done <= s1_last_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    // a full stage 1 behind a blocked output must hold and block the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && res_valid_reg && res_stall) |-> pix_stall)
        else $error("pixel accepted while both result stages are full");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && res_valid_reg && res_stall) |=> s1_valid_reg)
        else $error("stage-1 result lost while output stalled");

    // a line_length write restarts the reduced line at index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (ctl.index == '0))
        else $error("line restart did not clear the reduced index");

    // an item that drives the output register must come from stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        (!res_valid_reg && !s1_valid_reg) |=> !res_valid_reg)
        else $error("result appeared without a stage-1 item");
`endif

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mipmap_line_downsampler
// Streams parent pixel lines under several line lengths and reciprocals,
// mirrors the filter in a local predictor and checks every reduced pixel,
// field by field, against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module testbench;

    import mld_pkg::*;

    // register byte addresses on the configuration port
    localparam logic [ADDR_W-1:0] ADDR_LINE_LENGTH  = ADDR_W'(4 * int'(REG_LINE_LENGTH));
    localparam logic [ADDR_W-1:0] ADDR_RECIP_LENGTH = ADDR_W'(4 * int'(REG_RECIP_LENGTH));

    // two-stage pipeline; leave a few spare cycles for items that store only
    localparam int     SETTLE_CYCLES = 4;
    localparam int     RANDOM_ITEMS  = 800;
    localparam int     LONG_PART     = 64;
    localparam int     REPORT_LIMIT  = 10;
    // slowest run: under 1500 items, each with the longest input gap plus the
    // longest output stall, taken about six times over
    localparam longint TIME_LIMIT    = 10_000_000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              pix_valid = 1'b0;
    logic              pix_stall;
    pix_t              pix       = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    res_t              res;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // mirror of the block: registers, line positions and held pixels
    logic [LINE_LEN_BITS-1:0] line_length_q = LINE_LENGTH_RESET;
    logic [RECIP_BITS-1:0]    recip_q       = RECIP_LENGTH_RESET;
    int unsigned              next_in_pos   = 0;
    int unsigned              next_out_pos  = 0;
    pix_t                     first_pixel   = '0;
    pix_t                     middle_pixel  = '0;

    // reduced pixels predicted but not yet seen on res
    res_t pending_pixels[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int burst_left     = 0;

    mipmap_line_downsampler DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("MISMATCH: %s", msg);
    endfunction

    // line length as the block uses it: zero acts as one, clip at MAX_LINE
    function automatic int unsigned active_length(input logic [LINE_LEN_BITS-1:0] raw);
        int unsigned len;
        len = raw;
        if (len == 0)
            len = 1;
        if (len > MAX_LINE)
            len = MAX_LINE;
        return len;
    endfunction

    // mean of a pair, rounding half up
    function automatic logic [CHANNEL_BITS-1:0] pair_mean(input logic [CHANNEL_BITS-1:0] a, b);
        logic [CHANNEL_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b} + 1'b1;
        return sum[CHANNEL_BITS:1];
    endfunction

    // weighted triple scaled by the reciprocal, rounded and clipped
    function automatic logic [CHANNEL_BITS-1:0] three_tap(input int unsigned w0, w1, w2,
                                                          input logic [CHANNEL_BITS-1:0] a,
                                                          input logic [CHANNEL_BITS-1:0] b,
                                                          input logic [CHANNEL_BITS-1:0] c);
        longint unsigned acc;
        acc = 64'(w0) * 64'(recip_q) * 64'(a)
            + 64'(w1) * 64'(recip_q) * 64'(b)
            + 64'(w2) * 64'(recip_q) * 64'(c);
        acc = (acc + (64'd1 << (WEIGHT_BITS - 1))) >> WEIGHT_BITS;
        return ((acc >> CHANNEL_BITS) != 0) ? '1 : acc[CHANNEL_BITS-1:0];
    endfunction

    // advance the mirrored line by one parent pixel; queue any reduced pixel
    function automatic void predict_pixel(input pix_t p);
        int unsigned len;
        int unsigned pos;
        int unsigned half_len;
        int unsigned k;
        logic        last;
        logic        emit;
        res_t        r;
        len  = active_length(line_length_q);
        pos  = next_in_pos;
        last = (pos >= len - 1);
        emit = 1'b0;
        r    = '0;
        if (len == 1)
        begin
            r.out_x = p.chan_x;
            r.out_y = p.chan_y;
            r.out_z = p.chan_z;
            emit    = 1'b1;
        end
        else if ((len & 1) == 0)
        begin
            if ((pos & 1) == 0)
                first_pixel = p;
            else
            begin
                r.out_x = pair_mean(first_pixel.chan_x, p.chan_x);
                r.out_y = pair_mean(first_pixel.chan_y, p.chan_y);
                r.out_z = pair_mean(first_pixel.chan_z, p.chan_z);
                emit    = 1'b1;
            end
        end
        else
        begin
            half_len = len / 2;
            if ((pos & 1) == 1)
                middle_pixel = p;
            else if (pos == 0)
                first_pixel = p;
            else
            begin
                k = pos / 2 - 1;
                if (k >= half_len)
                    k = half_len - 1;
                r.out_x = three_tap(half_len - k, half_len, k + 1,
                                    first_pixel.chan_x, middle_pixel.chan_x, p.chan_x);
                r.out_y = three_tap(half_len - k, half_len, k + 1,
                                    first_pixel.chan_y, middle_pixel.chan_y, p.chan_y);
                r.out_z = three_tap(half_len - k, half_len, k + 1,
                                    first_pixel.chan_z, middle_pixel.chan_z, p.chan_z);
                // the end pixel opens the next triple
                first_pixel = p;
                emit        = 1'b1;
            end
        end
        if (emit)
        begin
            r.out_index    = next_out_pos[POS_W-1:0];
            r.line_done    = last;
            pending_pixels = {pending_pixels, r};
            next_out_pos++;
        end
        if (last)
        begin
            next_in_pos  = 0;
            next_out_pos = 0;
        end
        else
            next_in_pos = pos + 1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // mostly back to back, some short gaps, a few long ones, and bursts
    function automatic int pick_gap();
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            burst_left = $urandom_range(16, 64);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // bias toward the ends of the range so rounding and clipping are hit
    function automatic logic [CHANNEL_BITS-1:0] random_channel();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        if (roll == 2)
            return CHANNEL_BITS'({CHANNEL_BITS{1'b1}} - $urandom_range(1, 3));
        return CHANNEL_BITS'($urandom);
    endfunction

    function automatic pix_t random_pixel();
        pix_t p;
        p.chan_x = random_channel();
        p.chan_y = random_channel();
        p.chan_z = random_channel();
        return p;
    endfunction

    // Offer one parent pixel, hold it until taken, then predict from it.
    // Call at a rising edge; return at the edge that took the item.
    task automatic send_pixel(input pix_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        // stall is settled by the falling edge; it holds until the next rise
        do @(negedge clk); while (pix_stall);
        @(posedge clk);
        items_sent++;
        predict_pixel(p);
    endtask

    task automatic send_line(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(random_pixel());
    endtask

    // Drop valid, wait out every queued reduced pixel, then let items that
    // only store a pixel clear the pipeline.
    task automatic wait_idle();
        pix_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write a register (junk above the field), mirror it, then read it back.
    task automatic program_reg(input logic [ADDR_W-1:0] addr, input int unsigned value);
        logic [DATA_W-1:0] bus_word;
        logic [DATA_W-1:0] kept;
        bus_word = $urandom;
        if (addr == ADDR_LINE_LENGTH)
        begin
            bus_word[LINE_LEN_BITS-1:0] = value[LINE_LEN_BITS-1:0];
            kept = DATA_W'(value[LINE_LEN_BITS-1:0]);
        end
        else
        begin
            bus_word[RECIP_BITS-1:0] = value[RECIP_BITS-1:0];
            kept = DATA_W'(value[RECIP_BITS-1:0]);
        end
        // setup, then access
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= bus_word;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        @(posedge clk);
        // the write landed at this edge; a new line length restarts the line
        if (addr == ADDR_LINE_LENGTH)
        begin
            line_length_q = kept[LINE_LEN_BITS-1:0];
            next_in_pos   = 0;
            next_out_pos  = 0;
        end
        else
            recip_q = kept[RECIP_BITS-1:0];
        // keep psel high: this edge opens the read-back setup phase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        if (prdata !== kept)
            flag_mismatch($sformatf("register at %0d reads %h, expected %h",
                                    addr, prdata, kept));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // idle with psel low so the next access starts at a fresh edge
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset leaves length 2 and a zero reciprocal: pairs average, and an odd
    // line then gives all-zero results.
    task automatic test_reset_defaults();
        send_pixel(pix_t'{16'h0000, 16'hFFFF, 16'h0001});
        send_pixel(pix_t'{16'h0001, 16'hFFFF, 16'h0000});
        send_pixel(pix_t'{16'hFFFF, 16'h8000, 16'h7FFF});
        send_pixel(pix_t'{16'h0000, 16'h8001, 16'h7FFF});
        wait_idle();
        program_reg(ADDR_LINE_LENGTH, 3);
        repeat (3) send_pixel(pix_t'{16'hFFFF, 16'hFFFF, 16'hFFFF});
        wait_idle();
    endtask

    // Odd lines: a shared end pixel, a matching reciprocal, and an oversized
    // reciprocal that drives the sum into the clip.
    task automatic test_odd_triples();
        program_reg(ADDR_LINE_LENGTH, 5);
        program_reg(ADDR_RECIP_LENGTH, 13107);
        send_pixel(pix_t'{16'hFFFF, 16'h0000, 16'h0001});
        send_pixel(pix_t'{16'hFFFF, 16'h0000, 16'hFFFF});
        send_pixel(pix_t'{16'hFFFF, 16'h0000, 16'h8000});
        send_pixel(pix_t'{16'h0000, 16'hFFFF, 16'h7FFF});
        send_pixel(pix_t'{16'h0000, 16'hFFFF, 16'h0002});
        wait_idle();
        program_reg(ADDR_LINE_LENGTH, 3);
        program_reg(ADDR_RECIP_LENGTH, 65535);
        repeat (3) send_pixel(pix_t'{16'hFFFF, 16'hFFFF, 16'hFFFF});
        wait_idle();
    endtask

    // Length one passes pixels straight through; length zero acts as one.
    task automatic test_pass_through();
        program_reg(ADDR_LINE_LENGTH, 1);
        send_pixel(pix_t'{16'hFFFF, 16'h0000, 16'h5A5A});
        send_pixel(pix_t'{16'h0000, 16'hFFFF, 16'hA5A5});
        wait_idle();
        program_reg(ADDR_LINE_LENGTH, 0);
        send_pixel(pix_t'{16'h1234, 16'hFFFF, 16'h0000});
        send_pixel(pix_t'{16'hFFFF, 16'h0001, 16'hFFFE});
        wait_idle();
    endtask

    // A length write drops a half-done line; a reciprocal write mid-line
    // keeps the position and applies at once.
    task automatic test_line_rewrite();
        program_reg(ADDR_LINE_LENGTH, 6);
        send_line(3);
        wait_idle();
        program_reg(ADDR_LINE_LENGTH, 5);
        program_reg(ADDR_RECIP_LENGTH, 13107);
        send_line(2);
        wait_idle();
        program_reg(ADDR_RECIP_LENGTH, 21845);
        send_line(3);
        wait_idle();
    endtask

    // Random lengths and reciprocals, whole lines with random pixels and now
    // and then a partial line that the next length write abandons.
    task automatic test_random_lines();
        int          target;
        int          roll;
        int unsigned len;
        int unsigned eff;
        int unsigned recip;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            wait_idle();
            roll = $urandom_range(0, 19);
            if (roll == 0)
                len = 0;
            else if (roll == 1)
                len = 1;
            else if (roll < 17)
                len = $urandom_range(2, 16);
            else
                len = $urandom_range(17, 80);
            eff  = active_length(LINE_LEN_BITS'(len));
            roll = $urandom_range(0, 9);
            if (roll < 7)
                recip = (65536 + eff / 2) / eff;
            else if (roll == 7)
                recip = 0;
            else if (roll == 8)
                recip = 65535;
            else
                recip = $urandom_range(0, 65535);
            program_reg(ADDR_LINE_LENGTH, len);
            program_reg(ADDR_RECIP_LENGTH, recip);
            repeat ($urandom_range(1, 4)) send_line(eff);
            if (eff > 1 && $urandom_range(0, 4) == 0)
                send_line($urandom_range(1, eff - 1));
        end
        wait_idle();
    endtask

    // Full-size lengths: a length above the maximum runs as the longest even
    // line, and the longest odd line uses its largest tap weights; only the
    // start of each line is sent.
    task automatic test_longest_lines();
        program_reg(ADDR_LINE_LENGTH, 8191);
        send_line(LONG_PART);
        wait_idle();
        program_reg(ADDR_LINE_LENGTH, MAX_LINE - 1);
        program_reg(ADDR_RECIP_LENGTH, 16);
        send_line(LONG_PART);
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall and the result check
    // ------------------------------------------------------------------------

    // Alternate calm stretches, choppy stretches and the odd long stall.
    initial
    begin : stall_pattern
        int sel;
        int span;
        @(posedge clk);
        forever
        begin
            sel  = $urandom_range(0, 9);
            span = $urandom_range(8, 60);
            if (sel < 3)
            begin
                res_stall <= 1'b0;
                repeat (span) @(posedge clk);
            end
            else if (sel < 9)
            begin
                repeat (span)
                begin
                    res_stall <= ($urandom_range(0, 3) == 0);
                    @(posedge clk);
                end
            end
            else
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(10, 48)) @(posedge clk);
            end
        end
    end

    function automatic void compare_field(input string name, input int unsigned idx,
                                          input logic [15:0] want, input logic [15:0] got);
        if (got !== want)
            flag_mismatch($sformatf("reduced pixel %0d %s: expected %h, got %h",
                                    idx, name, want, got));
    endfunction

    // Sample on the falling edge: an item offered and not stalled here is
    // taken at the next rising edge.
    always @(negedge clk)
    begin : result_check
        res_t want;
        if (rst_n && res_valid === 1'b1 && res_stall == 1'b0)
        begin
            if (pending_pixels.size() == 0)
                flag_mismatch($sformatf("unexpected reduced pixel %0d", res.out_index));
            else
            begin
                want = pending_pixels.pop_front();
                compare_field("out_x", want.out_index, want.out_x, res.out_x);
                compare_field("out_y", want.out_index, want.out_y, res.out_y);
                compare_field("out_z", want.out_index, want.out_z, res.out_z);
                compare_field("out_index", want.out_index,
                              16'(want.out_index), 16'(res.out_index));
                compare_field("line_done", want.out_index,
                              16'(want.line_done), 16'(res.line_done));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_odd_triples();
        test_pass_through();
        test_line_rewrite();
        test_random_lines();
        test_longest_lines();
        wait_idle();
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // hard stop if the handshakes never finish
    initial
    begin
        #(TIME_LIMIT);
        $display("testbench failed");
        $finish;
    end

endmodule
